@@ hdl/rgpd_pkg.sv @@
// Shared types and constants for the range gate pass detector.
// No dependencies; imported by every module under hdl/.
package rgpd_pkg;

    localparam int TIME_BITS = 32;
    localparam int DIST_BITS = 13;
    localparam int IVL_BITS  = 16;
    localparam int SKIP_BITS = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;

    typedef enum logic [1:0] {
        FUNC_POLL     = 2'd0,
        FUNC_RESET    = 2'd1,
        FUNC_END_HOLD = 2'd2
    } t_func;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DIST = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DIST = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLDOFF  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP     = 3'd4;

    localparam logic [DIST_BITS-1:0] RST_MIN_DIST = 13'd0;
    localparam logic [DIST_BITS-1:0] RST_MAX_DIST = 13'd500;
    localparam logic [IVL_BITS-1:0]  RST_INTERVAL = 16'd25;
    localparam logic [IVL_BITS-1:0]  RST_HOLDOFF  = 16'd1000;
    localparam logic [SKIP_BITS-1:0] RST_SKIP     = 4'd1;

    typedef struct packed {
        t_func                func;
        logic [TIME_BITS-1:0] now_ms;
        logic [DIST_BITS-1:0] distance;
        logic                 detection_enabled;
        logic                 round_finished;
    } t_in_word;

    typedef struct packed {
        logic                 sample_taken;
        logic                 in_window;
        logic                 pass_detected;
        logic [TIME_BITS-1:0] pass_time_ms;
        logic                 rearmed;
        logic                 holdoff_active;
        logic [DIST_BITS-1:0] last_distance;
    } t_out_word;

    typedef struct packed {
        logic [DIST_BITS-1:0] min_distance;
        logic [DIST_BITS-1:0] max_distance;
        logic [IVL_BITS-1:0]  sample_interval_ms;
        logic [IVL_BITS-1:0]  holdoff_ms;
        logic [SKIP_BITS-1:0] skip_count;
    } t_cfg;

endpackage

@@ hdl/rgpd_cfg.sv @@
// Configuration register bank of the range gate pass detector.
// Depends on rgpd_pkg.
module rgpd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rgpd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [rgpd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output rgpd_pkg::t_cfg                      o_cfg
);
    import rgpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_distance       <= RST_MIN_DIST;
            r_cfg.max_distance       <= RST_MAX_DIST;
            r_cfg.sample_interval_ms <= RST_INTERVAL;
            r_cfg.holdoff_ms         <= RST_HOLDOFF;
            r_cfg.skip_count         <= RST_SKIP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_DIST: r_cfg.min_distance       <= i_cfg_data[DIST_BITS-1:0];
                CFG_MAX_DIST: r_cfg.max_distance       <= i_cfg_data[DIST_BITS-1:0];
                CFG_INTERVAL: r_cfg.sample_interval_ms <= i_cfg_data[IVL_BITS-1:0];
                CFG_HOLDOFF:  r_cfg.holdoff_ms         <= i_cfg_data[IVL_BITS-1:0];
                CFG_SKIP:     r_cfg.skip_count         <= i_cfg_data[SKIP_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/rgpd_core.sv @@
// Detector state and per-word decision logic (window, glitch skip, holdoff).
// Depends on rgpd_pkg.
module rgpd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rgpd_pkg::t_cfg      i_cfg,
    input  logic                i_fire,
    input  rgpd_pkg::t_in_word  i_word,
    output rgpd_pkg::t_out_word o_result
);
    import rgpd_pkg::*;

    logic                 r_holdoff, n_holdoff;
    logic [TIME_BITS-1:0] r_mark, n_mark;
    logic [TIME_BITS-1:0] r_hold_start, n_hold_start;
    logic [SKIP_BITS-1:0] r_glitch, n_glitch;
    logic [DIST_BITS-1:0] r_last, n_last;

    logic [TIME_BITS-1:0] since_mark;
    logic [TIME_BITS-1:0] since_hold;
    logic                 interval_done;
    logic                 holdoff_done;
    logic                 in_win;

    // wrapping time differences
    assign since_mark    = i_word.now_ms - r_mark;
    assign since_hold    = i_word.now_ms - r_hold_start;
    assign interval_done = since_mark >= TIME_BITS'(i_cfg.sample_interval_ms);
    assign holdoff_done  = since_hold >= TIME_BITS'(i_cfg.holdoff_ms);
    assign in_win        = (i_word.distance > i_cfg.min_distance) &&
                           (i_word.distance < i_cfg.max_distance);

    always_comb begin
        n_holdoff    = r_holdoff;
        n_mark       = r_mark;
        n_hold_start = r_hold_start;
        n_glitch     = r_glitch;
        n_last       = r_last;
        o_result     = '0;

        unique case (i_word.func)
            FUNC_RESET: begin
                n_glitch  = '0;
                n_holdoff = 1'b0;
                n_mark    = i_word.now_ms;
            end
            FUNC_END_HOLD: begin
                n_holdoff = 1'b0;
            end
            FUNC_POLL: begin
                if (!r_holdoff) begin
                    if (i_word.detection_enabled && interval_done) begin
                        o_result.sample_taken = 1'b1;
                        n_last = i_word.distance;
                        if (in_win) begin
                            o_result.in_window = 1'b1;
                            if (r_glitch < i_cfg.skip_count) begin
                                n_glitch = r_glitch + 1'b1;
                            end else begin
                                n_glitch     = '0;
                                n_hold_start = i_word.now_ms;
                                n_holdoff    = 1'b1;
                                n_mark       = i_word.now_ms;
                                o_result.pass_detected = 1'b1;
                                o_result.pass_time_ms  = i_word.now_ms;
                            end
                        end
                    end
                end else if (holdoff_done && !i_word.round_finished) begin
                    n_glitch  = '0;
                    n_holdoff = 1'b0;
                    n_mark    = i_word.now_ms;
                    o_result.rearmed = 1'b1;
                end
            end
            default: ;  // unused code: word ignored
        endcase

        o_result.holdoff_active = n_holdoff;
        o_result.last_distance  = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff    <= 1'b0;
            r_mark       <= '0;
            r_hold_start <= '0;
            r_glitch     <= '0;
            r_last       <= '0;
        end else if (i_fire) begin
            r_holdoff    <= n_holdoff;
            r_mark       <= n_mark;
            r_hold_start <= n_hold_start;
            r_glitch     <= n_glitch;
            r_last       <= n_last;
        end
    end

`ifndef SYNTH
    a_pass_enters_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.pass_detected) |=> (r_holdoff && r_glitch == '0 &&
            r_hold_start == $past(i_word.now_ms)))
        else $error("pass did not enter holdoff");

    a_rearm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.rearmed) |=> (!r_holdoff && r_glitch == '0 &&
            r_mark == $past(i_word.now_ms)))
        else $error("rearm did not clear detector state");

    a_sample_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.sample_taken) |=> (r_last == $past(i_word.distance)))
        else $error("sampled distance not held");

    a_events_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> !(o_result.rearmed && o_result.sample_taken))
        else $error("rearm and sample in one word");
`endif

endmodule

@@ hdl/range_gate_pass_detector.sv @@
// Top level of the range gate pass detector: input and result registers
// around rgpd_core, with the rgpd_cfg register bank. Depends on rgpd_pkg.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_stall| o_out_word (t_out_word)
//  cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output does not stall; a word's result
// reaches the output through the input register, then the result
// register.
// The detector state updates when a word moves from the input register to
// the result register; the compare and subtract logic sits on that path.
// A stall on a valid output holds the result register, and a full input
// register with it; the input stalls only while its register is full and cannot drain.
// Synchronous active-low reset empties both registers and restores the
// register defaults and detector state.
module range_gate_pass_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rgpd_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rgpd_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [rgpd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [rgpd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import rgpd_pkg::*;

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word result;
    logic      advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    rgpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rgpd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
